FILE: rtl/core/rbt_pkg.sv
// ----------------------------------------------------------------------------
// rbt_pkg: shared types and constants of the retransmit backoff table.
// Kind and event codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package rbt_pkg;

  localparam int TimeW   = 32;
  localparam int RetryW  = 4;
  localparam int SlotW   = 4;
  localparam int WaitW   = 31;
  localparam int ReasonW = 8;
  localparam int CfgIdxW = 8;
  localparam int CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_INIT_TIMEOUT   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINK_UP        = 8'd1;
  localparam logic [CfgW-1:0]    INIT_TIMEOUT_RESET = 16'd2000;

  typedef enum logic [1:0] {
    KIND_ADD, KIND_REMOVE, KIND_POLL, KIND_CANCEL
  } kind_e;

  typedef enum logic [2:0] {
    EV_ACCEPTED, EV_REJECTED, EV_FIRST_SEND, EV_RESEND,
    EV_TIMED_OUT, EV_CANCELLED, EV_REMOVED, EV_DONE
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD, ST_REM_RD, ST_REM, ST_POLL_RD, ST_POLL_LD,
    ST_POLL_IT, ST_POLL_WB, ST_CAN_RD, ST_CAN_EM, ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic do_add;
    logic rd_slot;
    logic do_remove;
    logic rd_scan;
    logic load;
    logic iter;
    logic wb;
    logic can_em;
    logic adv;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  live;
    logic  occupied;
    logic  last_slot;
    logic  stop;
  } status_t;

endpackage

FILE: rtl/core/retransmit_backoff_table_top.sv
// ----------------------------------------------------------------------------
// Retransmit backoff table: outstanding confirmable requests with backoff.
// Top level joining the sequencing state machine and the entry datapath.
// ----------------------------------------------------------------------------
// Usage. A request is taken when start_i is high and busy_o is low; its kind
// selects add, remove, poll or cancel-all, and the other request fields are
// sampled in that same cycle. Results come out one per cycle at most, each
// valid for exactly one cycle while res_valid_o is high; the final result of
// a request carries last_o. The receiver cannot stall, so results are never
// held back.
// Add writes its entry directly; remove first reads the entry, then clears
// it. Poll passes over free and skipped slots and, per handled slot, reads
// the entry through the single read port of the entry RAM, loads it, catches
// up its backoff one step per cycle and writes it back. Cancel-all visits
// each slot, reads and cancels each occupied one, then gives the done result.
// Configuration writes go through cfg_valid_i / cfg_ready_o (always ready) and
// must be made only while the block is idle.
// Reset clears all entry flags, sets the initial timeout to 2000 ms and marks
// the link down; the entry RAM itself is not cleared, as flags gate its use.
// ----------------------------------------------------------------------------
module retransmit_backoff_table_top #(
  parameter int SLOTS       = 16,
  parameter int MAX_RETRIES = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rbt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rbt_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   kind_i,
  input  logic [rbt_pkg::SlotW-1:0]    slot_i,
  input  logic [rbt_pkg::RetryW-1:0]   retry_budget_i,
  input  logic                         is_observation_i,
  input  logic                         awaiting_ack_i,
  input  logic [rbt_pkg::TimeW-1:0]    now_ms_i,
  input  logic [rbt_pkg::ReasonW-1:0]  reason_in_i,
  output logic                         res_valid_o,
  output logic [2:0]                   event_res_o,
  output logic [rbt_pkg::SlotW-1:0]    slot_out_o,
  output logic [rbt_pkg::RetryW-1:0]   retries_left_o,
  output logic [rbt_pkg::ReasonW-1:0]  reason_out_o,
  output logic [rbt_pkg::WaitW-1:0]    next_wait_o,
  output logic                         no_deadline_o,
  output logic                         last_o
);
  import rbt_pkg::*;

  cmd_t    cmd;
  status_t status;
  event_e  ev;

  // The configuration port never pushes back.
  assign cfg_ready_o = 1'b1;

  // The controller only sequences; all storage and arithmetic sit in the
  // datapath, and the two talk through the command and status bundles.
  rbt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  rbt_datapath #(
    .SLOTS       (SLOTS),
    .MAX_RETRIES (MAX_RETRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .kind_i           (kind_e'(kind_i)),
    .slot_i           (slot_i),
    .retry_budget_i   (retry_budget_i),
    .is_observation_i (is_observation_i),
    .awaiting_ack_i   (awaiting_ack_i),
    .now_ms_i         (now_ms_i),
    .reason_in_i      (reason_in_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .res_valid_o      (res_valid_o),
    .event_res_o      (ev),
    .slot_out_o       (slot_out_o),
    .retries_left_o   (retries_left_o),
    .reason_out_o     (reason_out_o),
    .next_wait_o      (next_wait_o),
    .no_deadline_o    (no_deadline_o),
    .last_o           (last_o)
  );

  assign event_res_o = ev;

  // The final result of a request appears as the block returns to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |-> !busy_o)
    else $error("final result while still busy");

endmodule

FILE: rtl/core/rbt_ram.sv
// ----------------------------------------------------------------------------
// rbt_ram: generic single-write, single-read RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rbt_ctrl.sv
// ----------------------------------------------------------------------------
// rbt_ctrl: sequencing state machine of the retransmit backoff table.
// Walks add, remove, poll scan with backoff catch-up, and cancel-all.
// ----------------------------------------------------------------------------
module rbt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  rbt_pkg::status_t status_i,
  output rbt_pkg::cmd_t    cmd_o
);
  import rbt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          unique case (status_i.kind)
            KIND_ADD:    state_d = ST_ADD;
            KIND_REMOVE: state_d = ST_REM_RD;
            KIND_POLL:   state_d = ST_POLL_RD;
            default:     state_d = ST_CAN_RD;
          endcase
        end
      end
      ST_ADD: begin
        cmd_o.do_add = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_REM_RD: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = ST_REM;
      end
      ST_REM: begin
        cmd_o.do_remove = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_POLL_RD: begin
        if (status_i.live) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = ST_POLL_LD;
        end else if (status_i.last_slot) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      ST_POLL_LD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_POLL_IT;
      end
      ST_POLL_IT: begin
        if (status_i.stop) begin
          state_d = ST_POLL_WB;
        end else begin
          cmd_o.iter = 1'b1;
        end
      end
      ST_POLL_WB: begin
        cmd_o.wb = 1'b1;
        if (status_i.last_slot) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ST_POLL_RD;
        end
      end
      ST_CAN_RD: begin
        if (status_i.occupied) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = ST_CAN_EM;
        end else if (status_i.last_slot) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      ST_CAN_EM: begin
        cmd_o.can_em = 1'b1;
        if (status_i.last_slot) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ST_CAN_RD;
        end
      end
      ST_DONE: begin
        cmd_o.emit_done = 1'b1;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // An accepted request always leaves the idle state.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("request accepted but not started");

  // The catch-up loop only runs on a poll.
  a_iter_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POLL_IT |-> status_i.kind == KIND_POLL)
    else $error("backoff iteration outside poll");

endmodule

FILE: rtl/core/rbt_datapath.sv
// ----------------------------------------------------------------------------
// rbt_datapath: entry storage, backoff arithmetic and result registers.
// Holds flags in flops, times and retries in a RAM, and the poll minimum.
// ----------------------------------------------------------------------------
module rbt_datapath #(
  parameter int SLOTS       = 16,
  parameter int MAX_RETRIES = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [rbt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rbt_pkg::CfgW-1:0]      cfg_data_i,
  input  rbt_pkg::kind_e                kind_i,
  input  logic [rbt_pkg::SlotW-1:0]     slot_i,
  input  logic [rbt_pkg::RetryW-1:0]    retry_budget_i,
  input  logic                          is_observation_i,
  input  logic                          awaiting_ack_i,
  input  logic [rbt_pkg::TimeW-1:0]     now_ms_i,
  input  logic [rbt_pkg::ReasonW-1:0]   reason_in_i,
  input  rbt_pkg::cmd_t                 cmd_i,
  output rbt_pkg::status_t              status_o,
  output logic                          res_valid_o,
  output rbt_pkg::event_e               event_res_o,
  output logic [rbt_pkg::SlotW-1:0]     slot_out_o,
  output logic [rbt_pkg::RetryW-1:0]    retries_left_o,
  output logic [rbt_pkg::ReasonW-1:0]   reason_out_o,
  output logic [rbt_pkg::WaitW-1:0]     next_wait_o,
  output logic                          no_deadline_o,
  output logic                          last_o
);
  import rbt_pkg::*;

  localparam int IdxW  = $clog2(SLOTS);
  localparam int EntW  = 2 * TimeW + RetryW;

  // Configuration registers.
  logic [CfgW-1:0] init_to_q;
  logic            link_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_to_q <= INIT_TIMEOUT_RESET;
      link_up_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_INIT_TIMEOUT) init_to_q <= cfg_data_i;
      if (cfg_index_i == CFG_LINK_UP)      link_up_q <= cfg_data_i[0];
    end
  end

  // Captured request.
  kind_e               kind_q;
  logic [SlotW-1:0]    slot_q;
  logic [RetryW-1:0]   budget_q;
  logic                obs_in_q, await_in_q;
  logic [TimeW-1:0]    now_q;
  logic [ReasonW-1:0]  reason_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= kind_i;
      slot_q     <= slot_i;
      budget_q   <= retry_budget_i;
      obs_in_q   <= is_observation_i;
      await_in_q <= awaiting_ack_i;
      now_q      <= now_ms_i;
      reason_q   <= reason_in_i;
    end
  end

  // Scan index and entry work registers.
  logic [IdxW-1:0]   idx_q;
  logic [TimeW-1:0]  st_q, to_q;
  logic [RetryW-1:0] rt_q;
  logic              resend_q, sent_q, have_min_q;
  logic [WaitW-1:0]  min_q;
  logic [SLOTS-1:0]  valid_q, obs_q, pend_q;

  logic              slot_ok;
  logic [IdxW-1:0]   slot_idx;
  logic [RetryW-1:0] budget_sat;
  logic [TimeW-1:0]  remain, init_to;
  logic              pending;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [EntW-1:0]   ram_wdata, ram_rdata;
  logic [TimeW-1:0]  rd_st, rd_to;
  logic [RetryW-1:0] rd_rt;

  assign slot_ok    = int'(slot_q) < SLOTS;
  assign slot_idx   = IdxW'(slot_q);
  assign budget_sat = (int'(budget_q) > MAX_RETRIES) ? RetryW'(MAX_RETRIES) : budget_q;
  assign remain     = st_q + to_q - now_q;
  assign pending    = (remain != '0) && !remain[TimeW-1];
  assign init_to    = (init_to_q == '0) ? TimeW'(1) : TimeW'(init_to_q);
  assign {rd_st, rd_to, rd_rt} = ram_rdata;

  assign status_o.kind      = cmd_i.capture ? kind_i : kind_q;
  assign status_o.occupied  = valid_q[idx_q];
  assign status_o.live      = valid_q[idx_q] && !(obs_q[idx_q] && !pend_q[idx_q]);
  assign status_o.last_slot = (idx_q == IdxW'(SLOTS - 1));
  assign status_o.stop      = pending || ((to_q != '0) && (rt_q == '0));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {st_q, to_q, rt_q};
    if (cmd_i.do_add && link_up_q && slot_ok) begin
      ram_we    = 1'b1;
      ram_waddr = slot_idx;
      ram_wdata = {now_q, {TimeW{1'b0}}, budget_sat};
    end else if (cmd_i.wb) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd_i.rd_slot ? slot_idx : idx_q;

  rbt_ram #(
    .WIDTH (EntW),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_q     <= rd_st;
      to_q     <= rd_to;
      rt_q     <= rd_rt;
      resend_q <= (rd_to != '0);
      sent_q   <= 1'b0;
    end else if (cmd_i.iter) begin
      sent_q <= 1'b1;
      if (to_q == '0) begin
        to_q <= init_to;
      end else begin
        st_q <= st_q + to_q;
        to_q <= to_q << 1;
        rt_q <= rt_q - RetryW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      have_min_q <= 1'b0;
      min_q      <= '0;
      valid_q    <= '0;
      obs_q      <= '0;
      pend_q     <= '0;
    end else begin
      if (cmd_i.capture) begin
        idx_q      <= '0;
        have_min_q <= 1'b0;
      end else if (cmd_i.adv) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.do_add && link_up_q && slot_ok) begin
        valid_q[slot_idx] <= 1'b1;
        obs_q[slot_idx]   <= obs_in_q;
        pend_q[slot_idx]  <= await_in_q;
      end
      if (cmd_i.do_remove && slot_ok) begin
        valid_q[slot_idx] <= 1'b0;
        obs_q[slot_idx]   <= 1'b0;
        pend_q[slot_idx]  <= 1'b0;
      end
      if ((cmd_i.wb && !pending) || cmd_i.can_em) begin
        valid_q[idx_q] <= 1'b0;
        obs_q[idx_q]   <= 1'b0;
        pend_q[idx_q]  <= 1'b0;
      end
      if (cmd_i.wb && pending && (!have_min_q || (remain[WaitW-1:0] < min_q))) begin
        min_q      <= remain[WaitW-1:0];
        have_min_q <= 1'b1;
      end
    end
  end

  // Result selection.
  logic              emit;
  event_e            ev;
  logic [SlotW-1:0]  ev_slot;
  logic [RetryW-1:0] ev_rt;
  logic [ReasonW-1:0] ev_reason;
  logic [WaitW-1:0]  ev_wait;
  logic              ev_nodl, ev_last;

  always_comb begin
    emit      = 1'b0;
    ev        = EV_DONE;
    ev_slot   = '0;
    ev_rt     = '0;
    ev_reason = '0;
    ev_wait   = '0;
    ev_nodl   = 1'b0;
    ev_last   = 1'b0;
    if (cmd_i.do_add) begin
      emit    = 1'b1;
      ev_slot = slot_q;
      ev_last = 1'b1;
      if (link_up_q && slot_ok) begin
        ev    = EV_ACCEPTED;
        ev_rt = budget_sat;
      end else begin
        ev = EV_REJECTED;
      end
    end else if (cmd_i.do_remove) begin
      emit    = 1'b1;
      ev      = EV_REMOVED;
      ev_slot = slot_q;
      ev_rt   = (slot_ok && valid_q[slot_idx]) ? rd_rt : '0;
      ev_last = 1'b1;
    end else if (cmd_i.wb) begin
      ev_slot = SlotW'(idx_q);
      if (!pending) begin
        emit = 1'b1;
        ev   = EV_TIMED_OUT;
      end else if (sent_q) begin
        emit  = 1'b1;
        ev    = resend_q ? EV_RESEND : EV_FIRST_SEND;
        ev_rt = rt_q;
      end
    end else if (cmd_i.can_em) begin
      emit      = !obs_q[idx_q];
      ev        = EV_CANCELLED;
      ev_slot   = SlotW'(idx_q);
      ev_rt     = rd_rt;
      ev_reason = reason_q;
    end else if (cmd_i.emit_done) begin
      emit    = 1'b1;
      ev_last = 1'b1;
      if (kind_q == KIND_POLL) begin
        ev_wait = have_min_q ? min_q : '0;
        ev_nodl = !have_min_q;
      end else begin
        ev_nodl = 1'b1;
      end
    end
  end

  logic res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      event_res_o    <= ev;
      slot_out_o     <= ev_slot;
      retries_left_o <= ev_rt;
      reason_out_o   <= ev_reason;
      next_wait_o    <= ev_wait;
      no_deadline_o  <= ev_nodl;
      last_o         <= ev_last;
    end
  end

  assign res_valid_o = res_valid_q;

  // A done result always closes the request.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && event_res_o == EV_DONE |-> last_o)
    else $error("done result without last");

endmodule
